>>> rtl/core/psba_pkg.sv
`default_nettype none
// Shared types and constants for the page slot bitmap allocator
package psba_pkg;

	// Sizing
	localparam int MAX_SLOTS = 1024;
	localparam int MAX_BATCH = 16;
	localparam int WORD_W    = 32;
	localparam int WORDS     = MAX_SLOTS / WORD_W;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int WADDR_W   = $clog2(WORDS);
	localparam int CNT_W     = SLOT_W + 1;
	localparam int REQ_W     = 5;
	localparam int PAGE_W    = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	// Command and register codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_PAGE   = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_NO_SPACE    = 2'd1,
		STAT_OUT_OF_RANGE = 2'd2,
		STAT_NOT_PRESENT = 2'd3
	} status_t;

	// Source of the slot field of a result
	typedef enum logic [1:0] {
		SLOT_ZERO,
		SLOT_GRANT,
		SLOT_RAW
	} slot_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_A_WAIT,
		S_A_SCAN,
		S_F_WAIT
	} psba_state_t;

	// Controller to datapath
	typedef struct packed {
		logic      latch;       // capture the input word
		logic      rd_first;    // read word 0, reset scan pointer
		logic      rd_next;     // read next word, advance scan pointer
		logic      rd_free;     // read word holding the named slot
		logic      load_work;   // take read data into the work word
		logic      grant;       // mark lowest free bit of the work word
		logic      wr_scan;     // write the work word back
		logic      free_clear;  // clear the named slot
		logic      emit;        // present a result
		status_t   stat;
		slot_sel_t slot_sel;
	} psba_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_free;
		logic req_zero;
		logic no_space;
		logic oor;
		logic found;
		logic run_last;
		logic present;
	} psba_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/psba_ctrl.sv
`default_nettype none
// Sequencer for allocate and free commands
module psba_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  psba_pkg::psba_sts_t  sts,
	output logic                 busy,
	output psba_pkg::psba_cmd_t  cmd
);

	psba_pkg::psba_state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psba_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			psba_pkg::S_IDLE: begin
				if (start) state_nxt = psba_pkg::S_DECIDE;
			end
			psba_pkg::S_DECIDE: begin
				if (sts.is_free) begin
					state_nxt = sts.oor ? psba_pkg::S_IDLE : psba_pkg::S_F_WAIT;
				end else if (sts.req_zero || sts.no_space) begin
					state_nxt = psba_pkg::S_IDLE;
				end else begin
					state_nxt = psba_pkg::S_A_WAIT;
				end
			end
			psba_pkg::S_A_WAIT: state_nxt = psba_pkg::S_A_SCAN;
			psba_pkg::S_A_SCAN: begin
				if (!sts.found) begin
					state_nxt = psba_pkg::S_A_WAIT;
				end else if (sts.run_last) begin
					state_nxt = psba_pkg::S_IDLE;
				end
			end
			psba_pkg::S_F_WAIT: state_nxt = psba_pkg::S_IDLE;
			default: state_nxt = psba_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		cmd.stat = psba_pkg::STAT_OK;
		cmd.slot_sel = psba_pkg::SLOT_ZERO;
		busy     = (state_q != psba_pkg::S_IDLE);
		unique case (state_q)
			psba_pkg::S_IDLE: begin
				cmd.latch = start;
			end
			psba_pkg::S_DECIDE: begin
				if (sts.is_free) begin
					if (sts.oor) begin
						cmd.emit = 1'b1;
						cmd.stat = psba_pkg::STAT_OUT_OF_RANGE;
					end else begin
						cmd.rd_free = 1'b1;
					end
				end else if (sts.req_zero) begin
					cmd.emit = 1'b1;
				end else if (sts.no_space) begin
					cmd.emit = 1'b1;
					cmd.stat = psba_pkg::STAT_NO_SPACE;
				end else begin
					cmd.rd_first = 1'b1;
				end
			end
			psba_pkg::S_A_WAIT: begin
				cmd.load_work = 1'b1;
			end
			psba_pkg::S_A_SCAN: begin
				if (sts.found) begin
					cmd.grant    = 1'b1;
					cmd.emit     = 1'b1;
					cmd.slot_sel = psba_pkg::SLOT_GRANT;
					cmd.wr_scan  = sts.run_last;
				end else begin
					cmd.wr_scan = 1'b1;
					cmd.rd_next = 1'b1;
				end
			end
			psba_pkg::S_F_WAIT: begin
				cmd.emit     = 1'b1;
				cmd.slot_sel = psba_pkg::SLOT_RAW;
				if (sts.present) begin
					cmd.free_clear = 1'b1;
				end else begin
					cmd.stat = psba_pkg::STAT_NOT_PRESENT;
				end
			end
			default: ;
		endcase
	end

	// A grant only when a free bit was found; reads only one at a time
	a_grant_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grant |-> sts.found) else $error("grant without free bit");
	a_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.rd_first, cmd.rd_next, cmd.rd_free}) <= 1)
		else $error("more than one read issued");

endmodule
`default_nettype wire

>>> rtl/core/psba_datapath.sv
`default_nettype none
// Bitmap word memory, occupied count, scan encoder and result registers
module psba_datapath (
	input  wire                                clk,
	input  wire                                arst_n,
	// item fields
	input  wire                                command,
	input  wire  [psba_pkg::REQ_W-1:0]         request_count,
	input  wire  signed [psba_pkg::CNT_W-1:0]  slot_number,
	input  wire  [psba_pkg::PAGE_W-1:0]        request_page,
	// register writes
	input  wire                                cfg_we,
	input  wire  [psba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [psba_pkg::CFG_DATA_W-1:0]    cfg_data,
	// control
	input  psba_pkg::psba_cmd_t                cmd,
	output psba_pkg::psba_sts_t                sts,
	// results
	output logic                               result_valid,
	output logic [1:0]                         status,
	output logic [psba_pkg::SLOT_W-1:0]        granted_slot,
	output logic                               last_of_run,
	output logic [psba_pkg::CNT_W-1:0]         free_slots
);

	localparam int W  = psba_pkg::WORD_W;
	localparam int AW = psba_pkg::WADDR_W;
	localparam int BW = psba_pkg::BIT_W;
	localparam int CW = psba_pkg::CNT_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(psba_pkg::MAX_SLOTS);

	// Config registers
	logic [CW-1:0]                   slot_count_q;
	logic [psba_pkg::PAGE_W-1:0]     own_page_q;
	logic                            clr_map;

	assign clr_map = cfg_we && (cfg_index == psba_pkg::REG_SLOT_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= MAX_CNT;
			own_page_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psba_pkg::REG_SLOT_COUNT: slot_count_q <= cfg_data[CW-1:0];
				psba_pkg::REG_OWN_PAGE:   own_page_q   <= cfg_data[psba_pkg::PAGE_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective count, capped
	logic [CW-1:0] eff;
	assign eff = (slot_count_q > MAX_CNT) ? MAX_CNT : slot_count_q;

	// Latched item
	logic                           cmd_q;
	logic [psba_pkg::REQ_W-1:0]     want_q;
	logic [CW-1:0]                  raw_q;
	logic [psba_pkg::PAGE_W-1:0]    page_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q  <= command;
			want_q <= request_count;
			raw_q  <= slot_number;
			page_q <= request_page;
		end
	end

	// Occupied count and scan state
	logic [CW-1:0]               occ_q, occ_nxt;
	logic [AW-1:0]               ptr_q;
	logic [psba_pkg::REQ_W-1:0]  got_q;
	logic [W-1:0]                work_q;

	always_comb begin
		occ_nxt = occ_q;
		if (cmd.grant) occ_nxt = occ_q + CW'(1);
		else if (cmd.free_clear) occ_nxt = occ_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (clr_map) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_nxt;
		end
	end

	// Word memory with per-word valid bits; an unwritten word reads as all free
	logic [W-1:0]  mem_q [psba_pkg::WORDS];
	logic [psba_pkg::WORDS-1:0] wvalid_q;
	logic [W-1:0]  rdata_q;
	logic          rvalid_q;
	logic          rd_en, wr_en;
	logic [AW-1:0] raddr, waddr;
	logic [W-1:0]  wdata, rword;

	assign rd_en = cmd.rd_first | cmd.rd_next | cmd.rd_free;
	assign raddr = cmd.rd_free  ? raw_q[BW +: AW] :
	               cmd.rd_first ? '0 : (ptr_q + AW'(1));
	assign rword = rvalid_q ? rdata_q : '0;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[waddr] <= wdata;
		if (rd_en) begin
			rdata_q  <= mem_q[raddr];
			rvalid_q <= wvalid_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
		end else if (clr_map) begin
			wvalid_q <= '0;
		end else if (wr_en) begin
			wvalid_q[waddr] <= 1'b1;
		end
	end

	// Slots past the effective count are never offered
	logic [W-1:0] in_range, avail, iso;
	logic [BW-1:0] idx;
	logic [AW:0]   eff_hi;
	logic [BW-1:0] eff_lo;

	assign eff_hi = eff[CW-1:BW];
	assign eff_lo = eff[BW-1:0];

	always_comb begin
		if ({1'b0, ptr_q} < eff_hi) begin
			in_range = '1;
		end else if ({1'b0, ptr_q} == eff_hi) begin
			in_range = (W'(1) << eff_lo) - W'(1);
		end else begin
			in_range = '0;
		end
	end

	// Lowest free bit: isolate, then encode
	assign avail = ~work_q & in_range;
	assign iso   = avail & (~avail + W'(1));

	always_comb begin
		idx = '0;
		for (int i = 0; i < W; i++) begin
			if (iso[i]) idx = idx | BW'(i);
		end
	end

	// Memory writes: scan write-back or freeing a slot
	logic [W-1:0] free_mask;
	assign free_mask = W'(1) << raw_q[BW-1:0];
	assign wr_en = cmd.wr_scan | cmd.free_clear;
	assign waddr = cmd.free_clear ? raw_q[BW +: AW] : ptr_q;
	assign wdata = cmd.free_clear ? (rword & ~free_mask) :
	               (work_q | (cmd.grant ? iso : '0));

	always_ff @(posedge clk) begin
		if (cmd.rd_first) ptr_q <= '0;
		else if (cmd.rd_next) ptr_q <= ptr_q + AW'(1);
		if (cmd.latch) got_q <= '0;
		else if (cmd.grant) got_q <= got_q + psba_pkg::REQ_W'(1);
		if (cmd.load_work) work_q <= rword;
		else if (cmd.grant) work_q <= work_q | iso;
	end

	// Status towards the controller
	logic [CW-1:0] free_now;
	assign free_now = eff - occ_q;

	always_comb begin
		sts.is_free  = (cmd_q == psba_pkg::CMD_FREE);
		sts.req_zero = (want_q == '0);
		sts.no_space = (want_q > psba_pkg::REQ_W'(psba_pkg::MAX_BATCH)) ||
		               ({{(CW-psba_pkg::REQ_W){1'b0}}, want_q} > free_now);
		sts.oor      = raw_q[CW-1] || ({1'b0, raw_q[CW-2:0]} >= eff);
		sts.found    = |avail;
		sts.run_last = ((got_q + psba_pkg::REQ_W'(1)) == want_q);
		sts.present  = (page_q == own_page_q) && rword[raw_q[BW-1:0]];
	end

	// Result registers
	logic                        res_valid_q;
	psba_pkg::status_t           stat_q;
	logic [psba_pkg::SLOT_W-1:0] slot_q;
	logic                        last_q;
	logic [CW-1:0]               free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			stat_q <= cmd.stat;
			last_q <= cmd.grant ? sts.run_last : 1'b1;
			free_q <= eff - occ_nxt;
			case (cmd.slot_sel)
				psba_pkg::SLOT_GRANT: slot_q <= {ptr_q, idx};
				psba_pkg::SLOT_RAW:   slot_q <= raw_q[psba_pkg::SLOT_W-1:0];
				default:              slot_q <= '0;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign status       = stat_q;
	assign granted_slot = slot_q;
	assign last_of_run  = last_q;
	assign free_slots   = free_q;

	// Occupied count never exceeds the page size; frees hit occupied slots only
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= eff) else $error("occupied count above slot count");
	a_free_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.free_clear |-> (occ_q != '0)) else $error("free with nothing occupied");

endmodule
`default_nettype wire

>>> rtl/core/page_slot_bitmap_allocator_top.sv
`default_nettype none
// First-fit slot allocator over a bitmap of 1024 slots held as 32-bit words in a
// single-port-write, single-port-read memory, one word read per access. A free
// command reads the word holding the named slot and gives one result. An allocate
// of k slots visits the bitmap words from word 0 to the word holding the last
// granted slot: each word is read, then scanned until it is found exhausted, and
// each granted slot is taken from the work word by the priority encoder. A
// zero-slot, no-space or out-of-range answer is given without a memory read.
// Results are strobed by result_valid for a single cycle and cannot be held off;
// a new command may be started on the cycle the final result of the previous one
// is strobed. Writing slot_count empties the bitmap; cfg_ready is high only while
// busy and start are both low.
module page_slot_bitmap_allocator_top (
	input  wire                                      clk,
	input  wire                                      arst_n,
	// command channel
	input  wire                                      start,
	output logic                                     busy,
	input  wire                                      command,
	input  wire  [psba_pkg::REQ_W-1:0]               request_count,
	input  wire  signed [psba_pkg::CNT_W-1:0]        slot_number,
	input  wire  [psba_pkg::PAGE_W-1:0]              request_page,
	// configuration channel
	input  wire                                      cfg_valid,
	output logic                                     cfg_ready,
	input  wire  [psba_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire  [psba_pkg::CFG_DATA_W-1:0]          cfg_data,
	// results
	output logic                                     result_valid,
	output logic [1:0]                               status,
	output logic [psba_pkg::SLOT_W-1:0]              granted_slot,
	output logic                                     last_of_run,
	output logic [psba_pkg::CNT_W-1:0]               free_slots
);

	psba_pkg::psba_cmd_t cmd;
	psba_pkg::psba_sts_t sts;
	logic                cfg_we;

	// Register writes only with nothing in flight and no word being taken
	assign cfg_ready = ~busy & ~start;
	assign cfg_we    = cfg_valid & cfg_ready;

	psba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	psba_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.command       (command),
		.request_count (request_count),
		.slot_number   (slot_number),
		.request_page  (request_page),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.result_valid  (result_valid),
		.status        (status),
		.granted_slot  (granted_slot),
		.last_of_run   (last_of_run),
		.free_slots    (free_slots)
	);

	// An accepted word starts work; every result comes from work in progress
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word did not start");
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result without work");

endmodule
`default_nettype wire

>>> bench/page_slot_bitmap_allocator_top_tb.sv
`timescale 1ns / 100ps

module page_slot_bitmap_allocator_top_tb;
	import psba_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		status_t             stat;
		logic [SLOT_W-1:0]   slot;
		logic                last;
		logic [CNT_W-1:0]    free_cnt;
	} slot_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     command = CMD_ALLOC;
	logic [REQ_W-1:0]         request_count = '0;
	logic signed [CNT_W-1:0]  slot_number = '0;
	logic [PAGE_W-1:0]        request_page = '0;
	logic                     cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_SLOT_COUNT;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     busy;
	logic                     cfg_ready;
	logic                     result_valid;
	logic [1:0]               status;
	logic [SLOT_W-1:0]        granted_slot;
	logic                     last_of_run;
	logic [CNT_W-1:0]         free_slots;

	// Mirror of the allocator state
	bit                       mirror_map [MAX_SLOTS];
	int                       mirror_used = 0;
	logic [CNT_W-1:0]         mirror_slot_count = 11'd1024;
	logic [PAGE_W-1:0]        mirror_page = '0;

	slot_result_t             due_results [$];
	int                       fail_count = 0;
	int                       cycle_count = 0;

	page_slot_bitmap_allocator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.request_count(request_count),
		.slot_number  (slot_number),
		.request_page (request_page),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.status       (status),
		.granted_slot (granted_slot),
		.last_of_run  (last_of_run),
		.free_slots   (free_slots)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run limit reached", $time);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Effective slot count, capped at the bitmap size
	function automatic int usable_slots();
		return (int'(mirror_slot_count) > MAX_SLOTS) ? MAX_SLOTS : int'(mirror_slot_count);
	endfunction

	function automatic int slots_left();
		return (mirror_used > usable_slots()) ? 0 : usable_slots() - mirror_used;
	endfunction

	function automatic void queue_result(status_t stat, int slot, bit last);
		slot_result_t r;
		r.stat     = stat;
		r.slot     = slot[SLOT_W-1:0];
		r.last     = last;
		r.free_cnt = CNT_W'(slots_left());
		due_results.insert(due_results.size(), r);
	endfunction

	// Expected results of one accepted command word
	function automatic void predict_slot_results(logic cmd, logic [REQ_W-1:0] cnt,
			logic [CNT_W-1:0] raw, logic [PAGE_W-1:0] page);
		int lim;
		int got;
		lim = usable_slots();
		got = 0;
		if (cmd == CMD_ALLOC) begin
			if (cnt == 0) begin
				queue_result(STAT_OK, 0, 1'b1);
			end else if (int'(cnt) > MAX_BATCH || int'(cnt) > slots_left()) begin
				queue_result(STAT_NO_SPACE, 0, 1'b1);
			end else begin
				// first fit, lowest slot first
				for (int i = 0; i < lim && got < int'(cnt); i++) begin
					if (!mirror_map[i]) begin
						mirror_map[i] = 1'b1;
						mirror_used++;
						got++;
						queue_result(STAT_OK, i, got == int'(cnt));
					end
				end
			end
		end else begin
			if (raw[CNT_W-1] || int'(raw) >= lim) begin
				queue_result(STAT_OUT_OF_RANGE, 0, 1'b1);
			end else if (page != mirror_page || !mirror_map[raw[SLOT_W-1:0]]) begin
				queue_result(STAT_NOT_PRESENT, int'(raw), 1'b1);
			end else begin
				mirror_map[raw[SLOT_W-1:0]] = 1'b0;
				if (mirror_used > 0)
					mirror_used--;
				queue_result(STAT_OK, int'(raw), 1'b1);
			end
		end
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Result checker, sampled on the rising edge
	always @(posedge clk) begin : result_check
		slot_result_t want;
		if (arst_n && result_valid) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result expected none got status %0d slot %0d",
					$time, status, granted_slot);
				fail_count++;
			end else begin
				want = due_results.pop_front();
				compare_field("status", want.stat, status);
				compare_field("granted_slot", want.slot, granted_slot);
				compare_field("last_of_run", want.last, last_of_run);
				compare_field("free_slots", want.free_cnt, free_slots);
			end
		end
	end

	// Send one command word and wait for it to be taken
	task automatic send_word(logic cmd, logic [REQ_W-1:0] cnt, logic [CNT_W-1:0] raw,
			logic [PAGE_W-1:0] page);
		@(negedge clk);
		command       = cmd;
		request_count = cnt;
		slot_number   = raw;
		request_page  = page;
		start         = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		predict_slot_results(cmd, cnt, raw, page);
	endtask

	task automatic alloc_word(int cnt);
		send_word(CMD_ALLOC, cnt[REQ_W-1:0], CNT_W'($urandom), $urandom);
	endtask

	task automatic free_word(int raw, logic [PAGE_W-1:0] page);
		send_word(CMD_FREE, REQ_W'($urandom), raw[CNT_W-1:0], page);
	endtask

	task automatic pause_sender(int cycles);
		@(negedge clk);
		start = 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		start = 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// Register write, only with the block idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		hold_until_drained();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		if (idx == REG_SLOT_COUNT) begin
			// new slot count formats the page
			mirror_slot_count = data[CNT_W-1:0];
			foreach (mirror_map[i])
				mirror_map[i] = 1'b0;
			mirror_used = 0;
		end else begin
			mirror_page = data;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int pick_used_slot();
		int lim;
		int first;
		lim = usable_slots();
		if (lim == 0)
			return 0;
		first = $urandom_range(lim - 1, 0);
		for (int k = 0; k < lim; k++) begin
			if (mirror_map[(first + k) % lim])
				return (first + k) % lim;
		end
		return first;
	endfunction

	// Zero request, full batch, oversized requests
	task automatic test_batch_limits();
		alloc_word(0);
		alloc_word(MAX_BATCH);
		alloc_word(MAX_BATCH + 1);
		alloc_word(31);
		alloc_word(1);
	endtask

	// Range, page and presence checks on free
	task automatic test_free_checks();
		free_word(3, 32'h0);
		free_word(3, 32'h0);
		free_word(5, 32'hFFFF_FFFF);
		free_word(11'h7FF, 32'h0);
		free_word(11'h400, 32'h0);
		free_word(1023, 32'h0);
		alloc_word(2);
	endtask

	// Page id rewrite keeps the bitmap
	task automatic test_page_rewrite();
		write_reg(REG_OWN_PAGE, 32'hFFFF_FFFF);
		free_word(5, 32'hFFFF_FFFF);
		free_word(6, 32'h0);
	endtask

	// Empty, single-slot and over-large pages
	task automatic test_slot_count_extremes();
		write_reg(REG_SLOT_COUNT, 32'd0);
		alloc_word(1);
		free_word(0, 32'hFFFF_FFFF);
		alloc_word(0);
		write_reg(REG_SLOT_COUNT, 32'd1);
		alloc_word(1);
		alloc_word(1);
		free_word(1, 32'hFFFF_FFFF);
		free_word(0, 32'hFFFF_FFFF);
		write_reg(REG_SLOT_COUNT, 32'd2047);
		free_word(1023, 32'hFFFF_FFFF);
		alloc_word(MAX_BATCH);
	endtask

	// Random traffic, mostly well-formed frees of live slots
	task automatic test_random_traffic(int n_items, int idle_pct, int count_lo, int count_hi,
			int alloc_pct, int batch_floor);
		int pick;
		int raw;
		logic [PAGE_W-1:0] page;
		write_reg(REG_SLOT_COUNT, $urandom_range(count_hi, count_lo));
		write_reg(REG_OWN_PAGE, $urandom);
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(99, 0) < idle_pct)
				pause_sender($urandom_range(12, 1));
			if ($urandom_range(99, 0) < 2)
				hold_until_drained();
			if ($urandom_range(99, 0) < alloc_pct) begin
				pick = $urandom_range(99, 0);
				if (pick < 6)
					alloc_word(0);
				else if (pick < 12)
					alloc_word($urandom_range(31, MAX_BATCH + 1));
				else
					alloc_word($urandom_range(MAX_BATCH, batch_floor));
			end else begin
				pick = $urandom_range(99, 0);
				page = mirror_page;
				if (pick < 70) begin
					raw = pick_used_slot();
				end else if (pick < 80) begin
					raw = (usable_slots() == 0) ? 0 : $urandom_range(usable_slots() - 1, 0);
				end else if (pick < 88) begin
					raw  = pick_used_slot();
					page = $urandom;
				end else begin
					raw = $urandom_range(2047, 0);
					if ($urandom_range(1, 0))
						page = $urandom;
				end
				free_word(raw, page);
			end
		end
	endtask

	task automatic finish_run();
		hold_until_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && due_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_batch_limits();
		test_free_checks();
		test_page_rewrite();
		test_slot_count_extremes();
		test_random_traffic(100, 15, 1, 64, 50, 1);
		test_random_traffic(130, 49, 1024, 1024, 85, 10);
		test_random_traffic(80, 0, 65, 2047, 55, 1);
		test_random_traffic(45, 0, 1, 16, 50, 1);
		finish_run();
	end

endmodule
